/* src/ascending_sorter_core_assert.svh */
// assertion macros for the ascending sorter checker
// no dependencies; taken in by `include
`ifndef ASCENDING_SORTER_CORE_ASSERT_SVH
`define ASCENDING_SORTER_CORE_ASSERT_SVH

// condition in this cycle implies condition in the next cycle
`define ASC_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("ascending sorter: next-cycle check failed");

// condition implies another in the same cycle
`define ASC_ASSERT_SAME(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
        else $error("ascending sorter: same-cycle check failed");

`endif

/* src/asc_pkg.sv */
// shared constants and types for the ascending sorter
// no dependencies
package asc_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef struct packed {
        logic insert;
        logic shift;
    } asc_ctrl_t;

endpackage

/* src/asc_if.sv */
// request channels of the ascending sorter: input samples and sorted results
// no dependencies
interface asc_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_value;
    logic                         is_last;

    modport source (output valid, output sample_value, output is_last, input ready);
    modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

interface asc_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         is_final;
    logic                         overflow;

    modport source (output valid, output sorted_value, output is_final, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input is_final, input overflow,
                    output ready);
endinterface

/* src/asc_cell.sv */
// one cell of the insertion chain: holds one element, inserts or shifts left
// depends on asc_pkg
module asc_cell
    import asc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  asc_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0] sample,
    input  logic                         occupied,
    input  logic signed [DATA_WIDTH-1:0] left_value,
    input  logic                         left_lt,
    input  logic signed [DATA_WIDTH-1:0] right_value,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic                         lt
);

    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;

    // empty cell counts as plus infinity
    assign lt    = !occupied || (sample < value_reg);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && lt)
        begin
            value_next = left_lt ? left_value : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* src/ascending_sorter_core.sv */
// channel   | direction | payload
// in_ch     | sink      | sample_value, is_last
// out_ch    | source    | sorted_value, is_final, overflow
//
// one sample is taken per cycle while a set is collected; each is inserted
// into the cell chain in that cycle, or dropped with overflow set if full.
// after the last sample the set drains one result per cycle from cell zero.
// no sample is taken while a set drains; a stalled result holds the chain.
// reset clears the fill count, overflow flag and state; no clearing pass.
// top level of the ascending sorter; depends on asc_pkg, asc_if, asc_cell
module ascending_sorter_core
    import asc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    asc_in_if.sink    in_ch,
    asc_out_if.source out_ch
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_DRAIN   = 2'b10
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         dropped_reg;
    logic                         dropped_next;
    logic                         in_fire;
    logic                         out_fire;
    logic                         full;
    asc_ctrl_t                    ctrl;
    logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];
    logic                         cell_lt    [DEPTH];
    logic                         occupied   [DEPTH];

    assign in_ch.ready = (state_reg == ST_COLLECT);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_ch.valid && out_ch.ready;
    assign full        = (count_reg == CNT_W'(DEPTH));

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_fire;

    assign out_ch.valid        = (state_reg == ST_DRAIN);
    assign out_ch.sorted_value = cell_value[0];
    assign out_ch.is_final     = (count_reg == CNT_W'(1));
    assign out_ch.overflow     = dropped_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] left_value;
            logic                         left_lt;
            logic signed [DATA_WIDTH-1:0] right_value;

            assign occupied[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_value = in_ch.sample_value;
                assign left_lt    = 1'b0;
            end
            else
            begin : g_inner
                assign left_value = cell_value[gi-1];
                assign left_lt    = cell_lt[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_mid
                assign right_value = cell_value[gi+1];
            end

            asc_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .sample      (in_ch.sample_value),
                .occupied    (occupied[gi]),
                .left_value  (left_value),
                .left_lt     (left_lt),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .lt          (cell_lt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_fire)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (in_ch.is_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (out_ch.is_final)
                    begin
                        dropped_next = 1'b0;
                        state_next   = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next   = ST_COLLECT;
                count_next   = '0;
                dropped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

/* src/asc_checker.sv */
// port-level checks of the ascending sorter, bound to the top level
// depends on ascending_sorter_core_assert.svh and ascending_sorter_core
`include "ascending_sorter_core_assert.svh"

module asc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_is_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_is_final
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    `ASC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASC_ASSERT_SAME(a_one_side, clk, rst_n, out_valid, !in_ready)
    `ASC_ASSERT_NEXT(a_last_drains, clk, rst_n, in_fire && in_is_last, out_valid)
    `ASC_ASSERT_NEXT(a_drain_goes_on, clk, rst_n, out_fire && !out_is_final, out_valid)
    `ASC_ASSERT_NEXT(a_final_frees, clk, rst_n, out_fire && out_is_final, in_ready)

endmodule

bind ascending_sorter_core asc_checker u_asc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_is_last   (in_ch.is_last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_final (out_ch.is_final)
);

/* sim/sorted_set_checker.sv */
// checker for the ascending sorter: watches the sample and result channels,
// predicts each sorted set and compares every result field by field
// depends on asc_pkg and asc_if
module sorted_set_checker
    import asc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    asc_in_if    samples,
    asc_out_if   results,
    output int   mismatches,
    output int   outstanding,
    output int   sets_seen,
    output int   results_seen,
    output int   overflow_sets
);

    typedef logic signed [DATA_WIDTH-1:0] sample_t;

    typedef struct {
        sample_t value;
        logic    last_flag;
        logic    ovf;
    } sorted_result_t;

    sample_t        held[DEPTH];
    int             held_count;
    logic           dropped;
    sorted_result_t sorted_q[$];

    task automatic report_mismatch(input string what);
        $display("%0t: result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    function automatic void take_sample(input sample_t v, input logic last);
        sample_t        ordered[DEPTH];
        sample_t        key;
        sorted_result_t r;
        int             i;
        int             j;
        if (held_count < DEPTH)
        begin
            held[held_count] = v;
            held_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (last)
        begin
            for (i = 0; i < held_count; i++)
                ordered[i] = held[i];
            for (i = 1; i < held_count; i++)
            begin
                key = ordered[i];
                j = i - 1;
                while (j >= 0)
                begin
                    if (ordered[j] <= key)
                        break;
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = key;
            end
            for (i = 0; i < held_count; i++)
            begin
                r.value     = ordered[i];
                r.last_flag = (i == held_count - 1);
                r.ovf       = dropped;
                sorted_q.insert(sorted_q.size(), r);
            end
            sets_seen++;
            if (dropped)
                overflow_sets++;
            held_count = 0;
            dropped    = 1'b0;
        end
    endfunction

    task automatic check_result();
        sorted_result_t want;
        if (sorted_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result, value %0d", results.sorted_value));
        end
        else
        begin
            want = sorted_q.pop_front();
            if (results.sorted_value !== want.value)
                report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                          results.sorted_value, want.value));
            if (results.is_final !== want.last_flag)
                report_mismatch($sformatf("is_final %b, expected %b",
                                          results.is_final, want.last_flag));
            if (results.overflow !== want.ovf)
                report_mismatch($sformatf("overflow %b, expected %b",
                                          results.overflow, want.ovf));
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            dropped    = 1'b0;
            sorted_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
                take_sample(samples.sample_value, samples.is_last);
            if (results.valid && results.ready)
                check_result();
            outstanding = sorted_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// top of the ascending sorter testbench: clock, reset, sample requests and
// result back-pressure; checking is done by sorted_set_checker
// depends on asc_pkg, asc_if, ascending_sorter_core and sorted_set_checker
module testbench;
    import asc_pkg::*;

    localparam int TOTAL_SAMPLES = 470;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 80;
    localparam int LIMIT_CYCLES  = 200000;

    logic clk;
    logic rst_n;

    asc_in_if  #(.DATA_WIDTH(DATA_WIDTH_DEFAULT)) in_ch ();
    asc_out_if #(.DATA_WIDTH(DATA_WIDTH_DEFAULT)) out_ch ();

    int mismatches;
    int pending;
    int sets_seen;
    int results_seen;
    int overflow_sets;

    int samples_sent;
    int cycle_count;
    bit hold_req;
    bit tx_burst;
    bit rx_burst;

    int directed_values[20] = '{
        32'h7FFFFFFF,
        32'h80000000, 32'h7FFFFFFF, 0, -1, 1, 32'h80000000, -1,
        3, 3, 3, 3,
        10, -10,
        6, 5, 4, 3, 2, 1
    };
    bit directed_last[20] = '{
        1,
        0, 0, 0, 0, 0, 0, 1,
        0, 0, 0, 1,
        0, 1,
        0, 0, 0, 0, 0, 1
    };
    int forced_sizes[3] = '{64, 65, 70};

    ascending_sorter_core #(
        .DEPTH      (DEPTH_DEFAULT),
        .DATA_WIDTH (DATA_WIDTH_DEFAULT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sorted_set_checker #(
        .DEPTH      (DEPTH_DEFAULT),
        .DATA_WIDTH (DATA_WIDTH_DEFAULT)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (in_ch),
        .results       (out_ch),
        .mismatches    (mismatches),
        .outstanding   (pending),
        .sets_seen     (sets_seen),
        .results_seen  (results_seen),
        .overflow_sets (overflow_sets)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h80000000;
                1:       return 32'h7FFFFFFF;
                2:       return 0;
                default: return -1;
            endcase
        end
        else if (pick <= 2)
        begin
            return int'($urandom_range(0, 7)) - 4;
        end
        return $urandom;
    endfunction

    task automatic send_sample(input int v, input bit last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= v;
        in_ch.is_last      <= last;
        do @(posedge clk); while (!in_ch.ready);
        samples_sent++;
    endtask

    task automatic send_set(input int size);
        int i;
        tx_burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < size; i++)
            send_sample(random_sample(), i == size - 1);
    endtask

    // result side: random stalls, bursts, and one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid && !hold_req);
        end
    end

    initial
    begin
        int i;
        int set_index;
        int size;
        int pick;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= '0;
        in_ch.is_last      <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, equal values, short and descending sets
        tx_burst = 1'b0;
        for (i = 0; i < 20; i++)
            send_sample(directed_values[i], directed_last[i]);

        set_index = 0;
        while (samples_sent < TOTAL_SAMPLES)
        begin
            if (set_index < 3)
            begin
                size = forced_sizes[set_index];
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    size = $urandom_range(63, 70);
                else if (pick <= 3)
                    size = $urandom_range(13, 63);
                else
                    size = $urandom_range(1, 12);
            end
            // block drains while results are held, so later requests stall
            if (set_index == 3)
                hold_req = 1'b1;
            send_set(size);
            if (set_index == 8 || set_index == 18)
            begin
                in_ch.valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            set_index++;
        end

        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d samples sent in %0d sets, %0d sorted results checked",
                 samples_sent, sets_seen, results_seen);
        $display("%0d sets dropped samples; one receiver hold-off of %0d cycles",
                 overflow_sets, HOLD_CYCLES);
        if (pending != 0)
            $display("%0d sorted results never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* ascending_sorter_core.f */
+incdir+src
src/asc_pkg.sv
src/asc_if.sv
src/asc_cell.sv
src/ascending_sorter_core.sv
src/asc_checker.sv
sim/sorted_set_checker.sv
sim/testbench.sv
